/* sv/slrg_pkg.sv */
`timescale 1ns / 1ps
package slrg_pkg;

	localparam int VALUE_W = 30;
	localparam int SEED_W = 32;

	localparam int DEF_TABLE_LENGTH = 55;
	localparam int DEF_SHORT_LAG = 24;
	localparam int DEF_SEED_STRIDE = 21;
	localparam int DEF_MODULUS = 1000000000;

	localparam int WARMUP_ROUNDS = 3;
	localparam int ROUND_W = 2;
	localparam int DIV_STEPS = 3;
	localparam int DIV_CNT_W = 2;

	localparam logic CMD_SEED = 1'b1;

	localparam int OP_W = 4;
	localparam int CND_W = 4;
	localparam int PC_W = 4;

	// datapath operations
	localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT    = 4'd1;
	localparam logic [OP_W-1:0] OP_DRAW_RD   = 4'd2;
	localparam logic [OP_W-1:0] OP_DRAW_OUT  = 4'd3;
	localparam logic [OP_W-1:0] OP_DIV       = 4'd4;
	localparam logic [OP_W-1:0] OP_SCAT_INIT = 4'd5;
	localparam logic [OP_W-1:0] OP_SCAT      = 4'd6;
	localparam logic [OP_W-1:0] OP_WARM_INIT = 4'd7;
	localparam logic [OP_W-1:0] OP_REF_INIT  = 4'd8;
	localparam logic [OP_W-1:0] OP_REF_RD    = 4'd9;
	localparam logic [OP_W-1:0] OP_REF_WR    = 4'd10;
	localparam logic [OP_W-1:0] OP_REF_END   = 4'd11;

	// jump conditions
	localparam logic [CND_W-1:0] C_NEVER     = 4'd0;
	localparam logic [CND_W-1:0] C_ALWAYS    = 4'd1;
	localparam logic [CND_W-1:0] C_NO_IN     = 4'd2;
	localparam logic [CND_W-1:0] C_SEED      = 4'd3;
	localparam logic [CND_W-1:0] C_RP_END    = 4'd4;
	localparam logic [CND_W-1:0] C_OUT_FREE  = 4'd5;
	localparam logic [CND_W-1:0] C_CNT_NZ    = 4'd6;
	localparam logic [CND_W-1:0] C_NOT_LAST  = 4'd7;
	localparam logic [CND_W-1:0] C_WARM_MORE = 4'd8;

	// program steps
	localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] S_DISP  = 4'd1;
	localparam logic [PC_W-1:0] S_CHK   = 4'd2;
	localparam logic [PC_W-1:0] S_DRD   = 4'd3;
	localparam logic [PC_W-1:0] S_DOUT  = 4'd4;
	localparam logic [PC_W-1:0] S_DWAIT = 4'd5;
	localparam logic [PC_W-1:0] S_DIV   = 4'd6;
	localparam logic [PC_W-1:0] S_SCI   = 4'd7;
	localparam logic [PC_W-1:0] S_SCAT  = 4'd8;
	localparam logic [PC_W-1:0] S_WARM  = 4'd9;
	localparam logic [PC_W-1:0] S_REF   = 4'd10;
	localparam logic [PC_W-1:0] S_RRD   = 4'd11;
	localparam logic [PC_W-1:0] S_RWR   = 4'd12;
	localparam logic [PC_W-1:0] S_REND  = 4'd13;
	localparam logic [PC_W-1:0] S_RRET  = 4'd14;
	localparam logic [PC_W-1:0] S_RDRW  = 4'd15;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CND_W-1:0] cnd;
		logic [PC_W-1:0]  target;
	} ctrl_t;

	typedef struct packed {
		logic no_in;
		logic seed;
		logic rp_end;
		logic out_free;
		logic cnt_nz;
		logic not_last;
		logic warm_more;
	} stat_t;

endpackage

/* sv/slrg_mem.sv */
`timescale 1ns / 1ps
module slrg_mem
	import slrg_pkg::*;
#(
	parameter int DEPTH = DEF_TABLE_LENGTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [VALUE_W-1:0]         wr_data,
	input  logic                       rd_en_a,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
	output logic [VALUE_W-1:0]         rd_data_a,
	input  logic                       rd_en_b,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
	output logic [VALUE_W-1:0]         rd_data_b
);

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic [VALUE_W-1:0] rd_a_q;
	logic [VALUE_W-1:0] rd_b_q;
	logic               vld_a_q;
	logic               vld_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en_a) begin
			rd_a_q <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_b_q <= mem[rd_addr_b];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en_a) begin
				vld_a_q <= vld_q[rd_addr_a];
			end
			if (rd_en_b) begin
				vld_b_q <= vld_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = vld_a_q ? rd_a_q : '0;
	assign rd_data_b = vld_b_q ? rd_b_q : '0;

endmodule

/* sv/slrg_seq.sv */
`timescale 1ns / 1ps
module slrg_seq
	import slrg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	function automatic ctrl_t rom(input logic [PC_W-1:0] a);
		ctrl_t w;
		unique case (a)
			S_IDLE:  w = '{OP_ACCEPT,    C_NO_IN,     S_IDLE};
			S_DISP:  w = '{OP_NOP,       C_SEED,      S_DIV};
			S_CHK:   w = '{OP_NOP,       C_RP_END,    S_REF};
			S_DRD:   w = '{OP_DRAW_RD,   C_NEVER,     S_IDLE};
			S_DOUT:  w = '{OP_DRAW_OUT,  C_OUT_FREE,  S_IDLE};
			S_DWAIT: w = '{OP_NOP,       C_ALWAYS,    S_DOUT};
			S_DIV:   w = '{OP_DIV,       C_CNT_NZ,    S_DIV};
			S_SCI:   w = '{OP_SCAT_INIT, C_NEVER,     S_IDLE};
			S_SCAT:  w = '{OP_SCAT,      C_CNT_NZ,    S_SCAT};
			S_WARM:  w = '{OP_WARM_INIT, C_NEVER,     S_IDLE};
			S_REF:   w = '{OP_REF_INIT,  C_NEVER,     S_IDLE};
			S_RRD:   w = '{OP_REF_RD,    C_NEVER,     S_IDLE};
			S_RWR:   w = '{OP_REF_WR,    C_NOT_LAST,  S_RRD};
			S_REND:  w = '{OP_REF_END,   C_WARM_MORE, S_REF};
			S_RRET:  w = '{OP_NOP,       C_SEED,      S_IDLE};
			S_RDRW:  w = '{OP_NOP,       C_ALWAYS,    S_DRD};
			default: w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
		endcase
		return w;
	endfunction

	assign ctrl = rom(pc_q);

	always_comb begin
		unique case (ctrl.cnd)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_IN:     take = stat.no_in;
			C_SEED:      take = stat.seed;
			C_RP_END:    take = stat.rp_end;
			C_OUT_FREE:  take = stat.out_free;
			C_CNT_NZ:    take = stat.cnt_nz;
			C_NOT_LAST:  take = stat.not_last;
			C_WARM_MORE: take = stat.warm_more;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= take ? ctrl.target : pc_q + PC_W'(1);
		end
	end

endmodule

/* sv/slrg_dp.sv */
`timescale 1ns / 1ps
module slrg_dp
	import slrg_pkg::*;
#(
	parameter int TABLE_LENGTH = DEF_TABLE_LENGTH,
	parameter int SHORT_LAG    = DEF_SHORT_LAG,
	parameter int SEED_STRIDE  = DEF_SEED_STRIDE,
	parameter int MODULUS      = DEF_MODULUS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ctrl_t                             ctrl,
	output stat_t                             stat,
	input  logic                              in_valid,
	input  logic                              command,
	input  logic signed [SEED_W-1:0]          seed,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [VALUE_W-1:0]                value,
	output logic                              wr_en,
	output logic [$clog2(TABLE_LENGTH)-1:0]   wr_addr,
	output logic [VALUE_W-1:0]                wr_data,
	output logic                              rd_en_a,
	output logic [$clog2(TABLE_LENGTH)-1:0]   rd_addr_a,
	input  logic [VALUE_W-1:0]                rd_data_a,
	output logic                              rd_en_b,
	output logic [$clog2(TABLE_LENGTH)-1:0]   rd_addr_b,
	input  logic [VALUE_W-1:0]                rd_data_b
);

	localparam int IDX_W = $clog2(TABLE_LENGTH);
	localparam int RP_W  = $clog2(TABLE_LENGTH + 1);
	localparam int CNT_W = (IDX_W > DIV_CNT_W) ? IDX_W : DIV_CNT_W;

	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TABLE_LENGTH - 1);
	localparam logic [IDX_W-1:0]   LAG      = IDX_W'(SHORT_LAG);
	localparam logic [IDX_W-1:0]   LAG_WRAP = IDX_W'(TABLE_LENGTH - SHORT_LAG);
	localparam logic [IDX_W:0]     STEP     = (IDX_W + 1)'(SEED_STRIDE % TABLE_LENGTH);
	localparam logic [IDX_W:0]     LEN_EXT  = (IDX_W + 1)'(TABLE_LENGTH);
	localparam logic [VALUE_W-1:0] MOD_V    = VALUE_W'(MODULUS);
	localparam logic [SEED_W-1:0]  MOD_S    = SEED_W'(MODULUS);
	localparam logic [SEED_W-1:0]  RECIP    =
		SEED_W'((64'd1 << SEED_W) / 64'(MODULUS));
	localparam logic [RP_W-1:0]    RP_END   = RP_W'(TABLE_LENGTH);

	logic                cmd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ROUND_W-1:0]  rounds_q;
	logic [RP_W-1:0]     rp_q;
	logic                out_valid_q;
	logic [SEED_W-1:0]   mag_q;
	logic [SEED_W-1:0]   quo_s1;
	logic [SEED_W-1:0]   rem_s2;
	logic [VALUE_W-1:0]  rem_q;
	logic [VALUE_W-1:0]  prev_q;
	logic [VALUE_W-1:0]  cur_q;
	logic [IDX_W-1:0]    slot_q;
	logic [VALUE_W-1:0]  value_q;

	logic [SEED_W-1:0]   seed_u;
	logic [SEED_W-1:0]   mag;
	logic [2*SEED_W-1:0] recip_prod;
	logic [SEED_W-1:0]   quo_mod;
	logic [VALUE_W-1:0]  rem_n;
	logic [IDX_W:0]      slot_sum;
	logic [IDX_W-1:0]    slot_n;
	logic [IDX_W-1:0]    scat_idx;
	logic [VALUE_W-1:0]  sub_x;
	logic [VALUE_W-1:0]  sub_y;
	logic [VALUE_W-1:0]  diff;
	logic [IDX_W-1:0]    ref_idx;
	logic [IDX_W-1:0]    partner;
	logic                out_free;

	// seed magnitude, most negative seed gives 2^31
	assign seed_u = seed;
	assign mag    = seed_u[SEED_W-1] ? (~seed_u + SEED_W'(1)) : seed_u;

	// |seed| mod modulus by reciprocal multiply, quotient low by at most one
	assign recip_prod = (2*SEED_W)'(mag_q) * (2*SEED_W)'(RECIP);
	assign quo_mod    = quo_s1 * MOD_S;
	assign rem_n      = (rem_s2 >= MOD_S) ? VALUE_W'(rem_s2 - MOD_S) : rem_s2[VALUE_W-1:0];

	// scatter slot walk
	assign slot_sum = {1'b0, slot_q} + STEP;
	assign slot_n   = (slot_sum >= LEN_EXT) ? IDX_W'(slot_sum - LEN_EXT) : slot_sum[IDX_W-1:0];
	assign scat_idx = (slot_n == '0) ? LAST_IDX : slot_n - IDX_W'(1);

	// shared modular subtract
	assign sub_x = (ctrl.op == OP_SCAT) ? prev_q : rd_data_a;
	assign sub_y = (ctrl.op == OP_SCAT) ? cur_q : rd_data_b;
	assign diff  = (sub_x >= sub_y) ? sub_x - sub_y : sub_x + MOD_V - sub_y;

	assign ref_idx = cnt_q[IDX_W-1:0];
	assign partner = (ref_idx < LAG) ? ref_idx + LAG_WRAP : ref_idx - LAG;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = ref_idx;
		wr_data   = diff;
		rd_en_a   = 1'b0;
		rd_addr_a = ref_idx;
		rd_en_b   = 1'b0;
		rd_addr_b = partner;
		unique case (ctrl.op)
			OP_SCAT_INIT: begin
				wr_en   = 1'b1;
				wr_addr = LAST_IDX;
				wr_data = rem_q;
			end
			OP_SCAT: begin
				wr_en   = 1'b1;
				wr_addr = scat_idx;
				wr_data = cur_q;
			end
			OP_REF_WR: begin
				wr_en = 1'b1;
			end
			OP_REF_RD: begin
				rd_en_a = 1'b1;
				rd_en_b = 1'b1;
			end
			OP_DRAW_RD: begin
				rd_en_a   = 1'b1;
				rd_addr_a = rp_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= 1'b0;
			cnt_q    <= '0;
			rounds_q <= '0;
			rp_q     <= RP_END;
		end else begin
			unique case (ctrl.op)
				OP_ACCEPT: begin
					if (in_valid) begin
						cmd_q <= command;
						cnt_q <= CNT_W'(DIV_STEPS - 1);
					end
				end
				OP_DIV:       cnt_q <= cnt_q - CNT_W'(1);
				OP_SCAT_INIT: cnt_q <= CNT_W'(TABLE_LENGTH - 2);
				OP_SCAT:      cnt_q <= cnt_q - CNT_W'(1);
				OP_WARM_INIT: rounds_q <= ROUND_W'(WARMUP_ROUNDS);
				OP_REF_INIT:  cnt_q <= '0;
				OP_REF_WR:    cnt_q <= cnt_q + CNT_W'(1);
				OP_REF_END: begin
					rp_q     <= '0;
					rounds_q <= rounds_q - ROUND_W'(1);
				end
				OP_DRAW_OUT: begin
					if (out_free) begin
						rp_q <= rp_q + RP_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_DRAW_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_ACCEPT: begin
				mag_q <= mag;
			end
			OP_DIV: begin
				quo_s1 <= recip_prod[2*SEED_W-1:SEED_W];
				rem_s2 <= mag_q - quo_mod;
				rem_q  <= rem_n;
			end
			OP_SCAT_INIT: begin
				prev_q <= rem_q;
				cur_q  <= VALUE_W'(1);
				slot_q <= '0;
			end
			OP_SCAT: begin
				cur_q  <= diff;
				prev_q <= cur_q;
				slot_q <= slot_n;
			end
			OP_DRAW_OUT: begin
				if (out_free) begin
					value_q <= rd_data_a;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.no_in     = !in_valid;
	assign stat.seed      = (cmd_q == CMD_SEED);
	assign stat.rp_end    = (rp_q >= RP_END);
	assign stat.out_free  = out_free;
	assign stat.cnt_nz    = (cnt_q != '0);
	assign stat.not_last  = (ref_idx != LAST_IDX);
	assign stat.warm_more = (cmd_q == CMD_SEED) && (rounds_q != ROUND_W'(1));

	assign out_valid = out_valid_q;
	assign value     = value_q;

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= RP_END)
		else $error("read position past table end");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (value_q < MOD_V))
		else $error("drawn value not below modulus");

	a_draw_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DRAW_OUT && out_free) |=>
			(out_valid_q && rp_q == RP_W'($past(rp_q) + RP_W'(1))))
		else $error("draw did not advance read position");

	a_refill_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_REF_END) |=> (rp_q == '0))
		else $error("refill did not rewind read position");

endmodule

/* sv/subtractive_lagged_random_generator.sv */
`timescale 1ns / 1ps
// Subtractive lagged generator, x[n] = x[n-TABLE_LENGTH] - x[n-SHORT_LAG] mod MODULUS, run by
// a 16-step microprogram over a single table memory with two registered read ports. A draw
// beat (command 0) returns the next table word; value/MODULUS is the uniform fraction. A
// draw passes from acceptance through the dispatch, check, read and output steps to the
// result register, and the next beat is taken once the output step finds the output free;
// every TABLE_LENGTH-th draw first refills the table in place (one read step and one write
// step per word). A reseed beat (command 1) gives no result and keeps the input stalled
// from acceptance through |seed| mod MODULUS by reciprocal multiplication, a scatter fill
// of every table word, then three warm-up refills. Drawing before any reseed gives zeros.
// A finished result waits in the output register while the next beat is taken in.
module subtractive_lagged_random_generator
	import slrg_pkg::*;
#(
	parameter int TABLE_LENGTH = DEF_TABLE_LENGTH,
	parameter int SHORT_LAG    = DEF_SHORT_LAG,
	parameter int SEED_STRIDE  = DEF_SEED_STRIDE,
	parameter int MODULUS      = DEF_MODULUS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     command,
	input  logic signed [SEED_W-1:0] seed,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [VALUE_W-1:0]       value
);

	localparam int IDX_W = $clog2(TABLE_LENGTH);

	ctrl_t              ctrl;
	stat_t              stat;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic               rd_en_a;
	logic [IDX_W-1:0]   rd_addr_a;
	logic [VALUE_W-1:0] rd_data_a;
	logic               rd_en_b;
	logic [IDX_W-1:0]   rd_addr_b;
	logic [VALUE_W-1:0] rd_data_b;

	assign in_stall = (ctrl.op != OP_ACCEPT);

	slrg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	slrg_dp #(
		.TABLE_LENGTH (TABLE_LENGTH),
		.SHORT_LAG    (SHORT_LAG),
		.SEED_STRIDE  (SEED_STRIDE),
		.MODULUS      (MODULUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_valid  (in_valid),
		.command   (command),
		.seed      (seed),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en_a   (rd_en_a),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_en_b   (rd_en_b),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

	slrg_mem #(
		.DEPTH (TABLE_LENGTH)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en_a   (rd_en_a),
		.rd_addr_a (rd_addr_a),
		.rd_data_a (rd_data_a),
		.rd_en_b   (rd_en_b),
		.rd_addr_b (rd_addr_b),
		.rd_data_b (rd_data_b)
	);

endmodule
